>>> hdl/odometry_pose_update_defines.svh
// Assertion macros for the pose update block
`ifndef ODOMETRY_POSE_UPDATE_DEFINES_SVH
`define ODOMETRY_POSE_UPDATE_DEFINES_SVH
`ifndef SYNTH
`define OPU_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define OPU_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define OPU_ASSERT_IMP(label, clk, rst_n, a, c)
`define OPU_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/opu_pkg.sv
`default_nettype none
package opu_pkg;
  localparam logic signed [33:0] PI_Q      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629714;
  localparam logic signed [63:0] GAIN_INV  = 64'sd652032874;
  localparam logic signed [47:0] ACC_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN   = -48'sh8000_0000_0000;

  // 2*pi as an unsigned divisor and floor(2^55 / TWO_PI_U) for the tick divide
  localparam logic [30:0] TWO_PI_U   = 31'd1686629714;
  localparam logic [24:0] TICK_RECIP = 25'((64'd1 << 55) / 64'd1686629714);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_ATAN, ST_HEAD, ST_SINCOS, ST_MULX, ST_MULY, ST_DIVI, ST_DIV, ST_DONE
  } state_t;

  // CORDIC micro-rotation mode
  typedef enum logic [1:0] {MODE_VECT, MODE_ROT} mode_t;

  typedef struct packed {
    logic  load;
    mode_t mode;
    logic  step;
  } cordic_ctl_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd210828714;  5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;   5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755422;   5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;    5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;    5'd9: r = 32'sd524287;
      5'd10: r = 32'sd262144;    5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;     5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;     5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;       5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;        5'd23: r = 32'sd32;
      5'd24: r = 32'sd16;        5'd25: r = 32'sd8;
      5'd26: r = 32'sd4;         5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/opu_cordic.sv
`default_nettype none
// Shared CORDIC micro-rotation unit, one iteration per step.
module opu_cordic (
  input  wire logic               clk,
  input  wire opu_pkg::cordic_ctl_t ctl,
  input  wire logic [4:0]         idx,
  input  wire logic signed [63:0] x_init,
  input  wire logic signed [63:0] y_init,
  input  wire logic signed [33:0] z_init,
  output logic signed [63:0]      x_out,
  output logic signed [63:0]      y_out,
  output logic signed [33:0]      z_out
);
  logic signed [63:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [33:0] z_r, z_nxt, at;
  logic               dir_pos;

  // one micro-rotation; direction from y sign (vectoring) or z sign (rotation)
  always_comb begin
    xs = x_r >>> idx;
    ys = y_r >>> idx;
    at = 34'(opu_pkg::atan_entry(idx));
    dir_pos = (ctl.mode == opu_pkg::MODE_VECT) ? !y_r[63] : !z_r[33];
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    if (ctl.load) begin
      x_nxt = x_init; y_nxt = y_init; z_nxt = z_init;
    end else if (ctl.step) begin
      if (ctl.mode == opu_pkg::MODE_VECT) begin
        x_nxt = dir_pos ? x_r + ys : x_r - ys;
        y_nxt = dir_pos ? y_r - xs : y_r + xs;
        z_nxt = dir_pos ? z_r + at : z_r - at;
      end else begin
        x_nxt = dir_pos ? x_r - ys : x_r + ys;
        y_nxt = dir_pos ? y_r + xs : y_r - xs;
        z_nxt = dir_pos ? z_r - at : z_r + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule
`default_nettype wire

>>> hdl/odometry_pose_update.sv
// Pose update, one request at a time. From acceptance: the arctangent pass on
// the shared CORDIC unit (CORDIC_STEPS iterations, capped at 32), a step to
// form and wrap the heading, the sin/cos pass on the same CORDIC unit, for
// each accumulator a 32x33 multiply and then a round and saturate step,
// forming |heading|*ticks_per_turn, and the divide by 2*pi (reciprocal
// multiply in two halves, a combine into the quotient estimate, then one
// correction step). The result stays on the out_ ports until taken; in_ready
// returns the cycle after. ticks_per_turn is written only while idle and
// takes effect on the next request.
`default_nettype none
`include "odometry_pose_update_defines.svh"
module odometry_pose_update #(
  parameter int CORDIC_STEPS = 28
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [24:0]        cfg_ticks_per_turn,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_rotation_increment,
  input  wire logic signed [31:0] in_distance_increment,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      out_x_position,
  output logic signed [47:0]      out_y_position,
  output logic signed [31:0]      out_heading_radians,
  output logic signed [24:0]      out_heading_ticks
);
  localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(NSTEPS - 1);

  opu_pkg::state_t     state_r, state_nxt;
  opu_pkg::cordic_ctl_t ctl;
  logic [24:0]         tpt_r;
  logic [5:0]          cnt_r, cnt_nxt;
  logic signed [33:0]  head_r, mean_r, old_r;
  logic signed [47:0]  x_acc_r, y_acc_r;
  logic signed [31:0]  dist_r;
  logic                neg_r, part_r;
  logic signed [63:0]  prod_r;
  logic [54:0]         num_r;   // |heading*ticks|
  logic [52:0]         lo_r, hi_r;
  logic [24:0]         quo_r;
  logic                qneg_r;
  logic signed [63:0]  cx, cy, x_init, y_init;
  logic signed [33:0]  cz, z_init, mean_adj, mean_c;

  opu_cordic u_cordic (
    .clk(clk), .ctl(ctl), .idx(cnt_r[4:0]), .x_init(x_init), .y_init(y_init),
    .z_init(z_init), .x_out(cx), .y_out(cy), .z_out(cz)
  );

  // configuration register
  assign cfg_ready = (state_r == opu_pkg::ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) tpt_r <= 25'd4096;
    else if (cfg_valid && cfg_ready) tpt_r <= cfg_ticks_per_turn;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      opu_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = opu_pkg::ST_ATAN;
      end
      opu_pkg::ST_ATAN: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[4:0] == LAST && cnt_r != 6'd0 || NSTEPS == 1) begin
          state_nxt = opu_pkg::ST_HEAD; cnt_nxt = '0;
        end
      end
      opu_pkg::ST_HEAD: begin state_nxt = opu_pkg::ST_SINCOS; cnt_nxt = '0; end
      opu_pkg::ST_SINCOS: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[4:0] == LAST) begin state_nxt = opu_pkg::ST_MULX; cnt_nxt = '0; end
      end
      opu_pkg::ST_MULX: if (part_r) state_nxt = opu_pkg::ST_MULY;
      opu_pkg::ST_MULY: if (part_r) state_nxt = opu_pkg::ST_DIVI;
      opu_pkg::ST_DIVI: if (part_r) begin state_nxt = opu_pkg::ST_DIV; cnt_nxt = '0; end
      opu_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) state_nxt = opu_pkg::ST_DONE;
      end
      opu_pkg::ST_DONE: if (out_ready) state_nxt = opu_pkg::ST_IDLE;
      default: state_nxt = opu_pkg::ST_IDLE;
    endcase
  end

  // outputs and CORDIC control
  always_comb begin
    in_ready = (state_r == opu_pkg::ST_IDLE);
    out_valid = (state_r == opu_pkg::ST_DONE);
    ctl.load = 1'b0; ctl.step = 1'b0; ctl.mode = opu_pkg::MODE_VECT;
    x_init = 64'sd1 <<< 32;
    y_init = 64'(in_rotation_increment) <<< 16;
    z_init = '0;
    mean_adj = mean_c;
    if (mean_c > opu_pkg::HALF_PI_Q) mean_adj = mean_c - opu_pkg::PI_Q;
    else if (mean_c < -opu_pkg::HALF_PI_Q) mean_adj = mean_c + opu_pkg::PI_Q;
    case (state_r)
      opu_pkg::ST_IDLE: ctl.load = in_valid;
      opu_pkg::ST_ATAN: ctl.step = 1'b1;
      opu_pkg::ST_HEAD: begin
        ctl.load = 1'b1; ctl.mode = opu_pkg::MODE_ROT;
        x_init = opu_pkg::GAIN_INV; y_init = '0; z_init = mean_adj;
      end
      opu_pkg::ST_SINCOS: begin ctl.step = 1'b1; ctl.mode = opu_pkg::MODE_ROT; end
      default: ctl.mode = opu_pkg::MODE_ROT;
    endcase
  end

  // datapath arithmetic
  logic signed [63:0] hsum, dprod, sat, cs_c;
  logic signed [64:0] mul_c;
  logic signed [47:0] acc_sel, acc_new;
  logic [30:0] abs_h;
  logic [55:0] tick_c, back_c, rem_c;
  logic [52:0] rmul_c;
  logic [80:0] qsum;
  always_comb begin
    hsum = 64'(old_r) + 64'(cz);
    // mean of old and new heading, before the wrap
    mean_c = 34'((64'(old_r) + hsum) >>> 1);
    cs_c = (state_r == opu_pkg::ST_MULX) ? cx : cy;
    if (neg_r) cs_c = -cs_c;
    mul_c = dist_r * signed'(cs_c[32:0]);
    dprod = prod_r + (64'sd1 <<< 29);
    acc_sel = (state_r == opu_pkg::ST_MULX) ? x_acc_r : y_acc_r;
    sat = 64'(acc_sel) + (dprod >>> 30);
    if (sat > 64'(opu_pkg::ACC_MAX)) acc_new = opu_pkg::ACC_MAX;
    else if (sat < 64'(opu_pkg::ACC_MIN)) acc_new = opu_pkg::ACC_MIN;
    else acc_new = sat[47:0];
    // tick count: |heading| * ticks, then multiply by the reciprocal of 2*pi
    abs_h = head_r[33] ? 31'(-head_r) : 31'(head_r);
    tick_c = abs_h * tpt_r;
    rmul_c = (cnt_r[0] ? {1'b0, num_r[54:28]} : num_r[27:0]) * opu_pkg::TICK_RECIP;
    qsum = {hi_r, 28'd0} + 81'(lo_r);
    back_c = quo_r * opu_pkg::TWO_PI_U;
    rem_c = {1'b0, num_r} - back_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opu_pkg::ST_IDLE;
      cnt_r <= '0; part_r <= 1'b0;
      head_r <= '0; x_acc_r <= '0; y_acc_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      case (state_r)
        opu_pkg::ST_IDLE: if (in_valid) begin
          dist_r <= in_distance_increment;
          old_r <= head_r;
        end
        opu_pkg::ST_HEAD: begin
          mean_r <= mean_c;
          if (hsum > 64'(opu_pkg::PI_Q)) head_r <= 34'(hsum - 64'(opu_pkg::TWO_PI_Q));
          else if (hsum <= -64'(opu_pkg::PI_Q)) head_r <= 34'(hsum + 64'(opu_pkg::TWO_PI_Q));
          else head_r <= hsum[33:0];
          neg_r <= 1'b0;
        end
        opu_pkg::ST_SINCOS: if (state_nxt == opu_pkg::ST_MULX) begin
          neg_r <= (mean_r > opu_pkg::HALF_PI_Q) || (mean_r < -opu_pkg::HALF_PI_Q);
          part_r <= 1'b0;
        end
        opu_pkg::ST_MULX, opu_pkg::ST_MULY: begin
          // part_r low: form product of distance and trig value; part_r high: accumulate
          part_r <= !part_r;
          if (!part_r) prod_r <= mul_c[63:0];
          else if (state_r == opu_pkg::ST_MULX) x_acc_r <= acc_new;
          else y_acc_r <= acc_new;
        end
        opu_pkg::ST_DIVI: begin
          part_r <= !part_r;
          if (!part_r) begin
            num_r <= tick_c[54:0];
            qneg_r <= head_r[33];
          end
        end
        opu_pkg::ST_DIV: begin
          // quotient estimate is exact or one low; the last cycle corrects it
          if (cnt_r[1:0] == 2'd0) lo_r <= rmul_c;
          else if (cnt_r[1:0] == 2'd1) hi_r <= rmul_c;
          else if (cnt_r[1:0] == 2'd2) quo_r <= qsum[79:55];
          else if (rem_c >= 56'(opu_pkg::TWO_PI_U)) quo_r <= quo_r + 25'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_x_position = x_acc_r;
  assign out_y_position = y_acc_r;
  assign out_heading_radians = head_r[31:0];
  assign out_heading_ticks = qneg_r ? -quo_r : quo_r;

  `OPU_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != opu_pkg::ST_IDLE, !in_ready)
  `OPU_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, out_valid == 1'b0)
  `OPU_ASSERT_IMP(a_heading_wrapped, clk, rst_n, out_valid,
    (head_r <= opu_pkg::PI_Q) && (head_r > -opu_pkg::PI_Q))
endmodule
`default_nettype wire
